FILE: rtl/core/dmhc_pkg.sv
package dmhc_pkg;

  // Cache geometry
  localparam int INDEX_BITS   = 10;
  localparam int NUM_VALUES   = 5;
  localparam int MAX_VALUES   = 5;
  localparam int SLOT_COUNT   = 1 << INDEX_BITS;
  localparam int SLOT_W       = (INDEX_BITS > 0) ? INDEX_BITS : 1;

  // Key and result words
  localparam int KEY_LEN    = 29;
  localparam int KEY_BITS   = KEY_LEN * 8;
  localparam int BYTE_CNT_W = $clog2(KEY_LEN);
  localparam int WORD_W     = 32;
  localparam int VAL_BITS   = NUM_VALUES * WORD_W;
  localparam int OUT_BITS   = MAX_VALUES * WORD_W;

  // FNV-1a 64-bit
  localparam logic [63:0] HASH_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] HASH_PRIME = 64'h0000_0100_0000_01b3;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_STORE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] slot;
  } hash_st_t;

  typedef struct packed {
    logic              en;
    logic              fill;   // 1: store key/values and set valid, 0: clear valid
    logic [SLOT_W-1:0] addr;
  } slot_wr_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [VAL_BITS-1:0] vals;
  } slot_rd_t;

endpackage

FILE: rtl/core/dmhc_req_if.sv
interface dmhc_req_if;
  import dmhc_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] key_bytes_0_7;
  logic [63:0] key_bytes_8_15;
  logic [63:0] key_bytes_16_23;
  logic [39:0] key_bytes_24_28;
  logic [WORD_W-1:0] value_in_0;
  logic [WORD_W-1:0] value_in_1;
  logic [WORD_W-1:0] value_in_2;
  logic [WORD_W-1:0] value_in_3;
  logic [WORD_W-1:0] value_in_4;

  modport source (
    output valid, opcode, key_bytes_0_7, key_bytes_8_15, key_bytes_16_23,
           key_bytes_24_28, value_in_0, value_in_1, value_in_2, value_in_3,
           value_in_4,
    input  ready
  );

  modport sink (
    input  valid, opcode, key_bytes_0_7, key_bytes_8_15, key_bytes_16_23,
           key_bytes_24_28, value_in_0, value_in_1, value_in_2, value_in_3,
           value_in_4,
    output ready
  );
endinterface

FILE: rtl/core/dmhc_rsp_if.sv
interface dmhc_rsp_if;
  import dmhc_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [WORD_W-1:0] value_out_0;
  logic [WORD_W-1:0] value_out_1;
  logic [WORD_W-1:0] value_out_2;
  logic [WORD_W-1:0] value_out_3;
  logic [WORD_W-1:0] value_out_4;
  logic [31:0]       hit_count;
  logic [31:0]       miss_count;
  logic [31:0]       store_count;

  modport source (
    output valid, hit, value_out_0, value_out_1, value_out_2, value_out_3,
           value_out_4, hit_count, miss_count, store_count,
    input  ready
  );

  modport sink (
    input  valid, hit, value_out_0, value_out_1, value_out_2, value_out_3,
           value_out_4, hit_count, miss_count, store_count,
    output ready
  );
endinterface

FILE: rtl/core/direct_mapped_hash_cache_unit.sv
// Channel  Dir  Payload                                        Transfer
// -------  ---  ---------------------------------------------  ------------------
// req      in   opcode, key_bytes_*, value_in_0..4             valid & ready
// rsp      out  hit, value_out_0..4, hit/miss/store_count      valid & ready
//
// Lookup and store pass from transfer to result register in order: one
// byte of the key per cycle through the FNV-1a hasher, then one
// registered read of the slot memory, then compare and load of the result
// register once rsp is drained. Counter clear and unused opcodes skip the
// hasher and the read. req is ready again from the edge that loads the
// result, so a lookup or store completes before the next transfer.
// After reset a sweep clears the slot valid bits, one slot per cycle
// (SLOT_COUNT = 1024 slots); req stays low meanwhile.
// The result register frees req from rsp: a new item is taken while the last
// result still waits; it stalls only in its final cycle if rsp is not drained.
module direct_mapped_hash_cache_unit (
  input logic       clk,
  input logic       rst,
  dmhc_req_if.sink  req,
  dmhc_rsp_if.source rsp
);
  import dmhc_pkg::*;

  state_t state;
  state_t state_next;

  logic [SLOT_W-1:0]   clr_idx;
  logic [1:0]          op_q;
  logic [VAL_BITS-1:0] vals_q;

  // hasher and memory wiring
  logic                hash_start;
  hash_st_t            hst;
  logic [KEY_BITS-1:0] key_cur;
  logic [KEY_BITS-1:0] key_in;
  logic                rd_en;
  slot_wr_t            wr;
  slot_rd_t            rd;

  // result side
  logic                rsp_valid;
  logic                rsp_hit;
  logic [OUT_BITS-1:0] rsp_vals;
  logic [31:0]         hits;
  logic [31:0]         misses;
  logic [31:0]         stores;
  logic [31:0]         hits_next;
  logic [31:0]         misses_next;
  logic [31:0]         stores_next;
  logic                out_free;
  logic                fin;
  logic                match;

  assign key_in = {req.key_bytes_24_28, req.key_bytes_16_23,
                   req.key_bytes_8_15, req.key_bytes_0_7};

  dmhc_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key_in (key_in),
    .st     (hst),
    .key    (key_cur)
  );

  dmhc_slot_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (hst.slot),
    .wr      (wr),
    .wr_key  (key_cur),
    .wr_vals (vals_q),
    .rd      (rd)
  );

  assign out_free = !rsp_valid || rsp.ready;
  assign match    = rd.valid && (rd.key == key_cur);

  // control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    hash_start = 1'b0;
    rd_en      = 1'b0;
    wr.en      = 1'b0;
    wr.fill    = 1'b0;
    wr.addr    = hst.slot;
    req.ready  = 1'b0;
    fin        = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_idx;
        if (clr_idx == SLOT_W'(SLOT_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.opcode == OP_LOOKUP || req.opcode == OP_STORE) begin
            hash_start = 1'b1;
            state_next = ST_HASH;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_HASH: begin
        // slot index final on done: read the slot
        if (hst.done) begin
          rd_en      = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          fin        = 1'b1;
          state_next = ST_IDLE;
          if (op_q == OP_STORE) begin
            wr.en   = 1'b1;
            wr.fill = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q   <= req.opcode;
      vals_q <= VAL_BITS'({req.value_in_4, req.value_in_3, req.value_in_2,
                           req.value_in_1, req.value_in_0});
    end
  end

  // counter update for the finishing item
  always_comb begin
    hits_next   = hits;
    misses_next = misses;
    stores_next = stores;
    unique case (op_q)
      OP_LOOKUP: begin
        if (match) begin
          hits_next = hits + 32'd1;
        end else begin
          misses_next = misses + 32'd1;
        end
      end
      OP_STORE: begin
        stores_next = stores + 32'd1;
      end
      OP_CLEAR: begin
        hits_next   = '0;
        misses_next = '0;
        stores_next = '0;
      end
      default: begin
        hits_next = hits;
      end
    endcase
  end

  // counters only move on fin, which waits for the result register to
  // drain, so they double as the result's count fields
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      hits      <= '0;
      misses    <= '0;
      stores    <= '0;
    end else begin
      if (fin) begin
        rsp_valid <= 1'b1;
        hits      <= hits_next;
        misses    <= misses_next;
        stores    <= stores_next;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      if (op_q == OP_LOOKUP && match) begin
        rsp_hit  <= 1'b1;
        rsp_vals <= OUT_BITS'(rd.vals);
      end else begin
        rsp_hit  <= 1'b0;
        rsp_vals <= '0;
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.hit         = rsp_hit;
  assign rsp.value_out_0 = rsp_vals[0*WORD_W +: WORD_W];
  assign rsp.value_out_1 = rsp_vals[1*WORD_W +: WORD_W];
  assign rsp.value_out_2 = rsp_vals[2*WORD_W +: WORD_W];
  assign rsp.value_out_3 = rsp_vals[3*WORD_W +: WORD_W];
  assign rsp.value_out_4 = rsp_vals[4*WORD_W +: WORD_W];
  assign rsp.hit_count   = hits;
  assign rsp.miss_count  = misses;
  assign rsp.store_count = stores;

endmodule

FILE: rtl/core/dmhc_hash.sv
module dmhc_hash (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dmhc_pkg::KEY_BITS-1:0] key_in,
  output dmhc_pkg::hash_st_t            st,
  output logic [dmhc_pkg::KEY_BITS-1:0] key
);
  import dmhc_pkg::*;

  // only the low slot bits of the 64-bit hash reach the index, and those
  // depend only on the low bits of the running value
  localparam logic [SLOT_W-1:0] PRIME_LO = HASH_PRIME[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] BASIS_LO = HASH_BASIS[SLOT_W-1:0];

  logic [KEY_BITS-1:0]   key_sr;
  logic [SLOT_W-1:0]     h;
  logic [SLOT_W-1:0]     mix;
  logic [SLOT_W-1:0]     h_next;
  logic [BYTE_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;

  assign mix    = h ^ SLOT_W'(key_sr[7:0]);
  assign h_next = SLOT_W'(mix * PRIME_LO);

  // byte ring: after KEY_LEN rotations the key is back in place
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == BYTE_CNT_W'(KEY_LEN - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_sr <= key_in;
      h      <= BASIS_LO;
      cnt    <= '0;
    end else if (busy) begin
      key_sr <= {key_sr[7:0], key_sr[KEY_BITS-1:8]};
      h      <= h_next;
      cnt    <= cnt + 1'b1;
    end
  end

  assign st.done = done;
  assign st.slot = (INDEX_BITS == 0) ? '0 : h;
  assign key     = key_sr;

endmodule

FILE: rtl/core/dmhc_slot_mem.sv
module dmhc_slot_mem (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [dmhc_pkg::SLOT_W-1:0]   rd_addr,
  input  dmhc_pkg::slot_wr_t            wr,
  input  logic [dmhc_pkg::KEY_BITS-1:0] wr_key,
  input  logic [dmhc_pkg::VAL_BITS-1:0] wr_vals,
  output dmhc_pkg::slot_rd_t            rd
);
  import dmhc_pkg::*;

  logic                valid_mem [SLOT_COUNT];
  logic [KEY_BITS-1:0] key_mem   [SLOT_COUNT];
  logic [VAL_BITS-1:0] val_mem   [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      valid_mem[wr.addr] <= wr.fill;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.fill) begin
      key_mem[wr.addr] <= wr_key;
      val_mem[wr.addr] <= wr_vals;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.valid <= valid_mem[rd_addr];
      rd.key   <= key_mem[rd_addr];
      rd.vals  <= val_mem[rd_addr];
    end
  end

endmodule
